/* hw/rtl/tope_pkg.sv */
// tope_pkg: shared types, codes and character helpers for the tree object entry parser
// depends on nothing; used by tope_parser and tree_object_entry_parser

package tope_pkg;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_MODE   = 2'd1,
        PH_NAME   = 2'd2,
        PH_HASH   = 2'd3
    } phase_t;

    localparam logic [1:0] KIND_DELIM = 2'd0;
    localparam logic [1:0] KIND_MODE  = 2'd1;
    localparam logic [1:0] KIND_NAME  = 2'd2;
    localparam logic [1:0] KIND_HASH  = 2'd3;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] TREE_MODE_LEN = 3'd6;
    localparam logic [2:0] MODE_LEN_MAX  = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] char_count;
        logic [7:0] first_char;
        logic [7:0] second_char;
        logic       entry_done;
        logic       is_subtree;
        logic       object_end;
        logic       parse_error;
    } result_t;

    // characters of the subtree mode text "040000"
    function automatic logic [7:0] tree_mode_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd1:    c = 8'h34;
            3'd0,
            3'd2,
            3'd3,
            3'd4,
            3'd5:    c = 8'h30;
            default: c = CHAR_NUL;
        endcase
        return c;
    endfunction

    // lower-case hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h57 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/tope_in_if.sv */
// tope_in_if: input channel carrying one tree object byte per beat
// depends on nothing

interface tope_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       object_last;

    modport source (output valid, output data_byte, output object_last, input ready);
    modport sink   (input valid, input data_byte, input object_last, output ready);
endinterface

/* hw/rtl/tope_out_if.sv */
// tope_out_if: result channel carrying one parse result per beat
// depends on nothing

interface tope_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] char_count;
    logic [7:0] first_char;
    logic [7:0] second_char;
    logic       entry_done;
    logic       is_subtree;
    logic       object_end;
    logic       parse_error;

    modport source (output valid, output kind, output char_count, output first_char,
                    output second_char, output entry_done, output is_subtree,
                    output object_end, output parse_error, input ready);
    modport sink   (input valid, input kind, input char_count, input first_char,
                    input second_char, input entry_done, input is_subtree,
                    input object_end, input parse_error, output ready);
endinterface

/* hw/rtl/tree_object_entry_parser.sv */
// tree_object_entry_parser: top level, byte-wise tree object entry parser
// depends on tope_pkg, tope_in_if, tope_out_if, tope_parser
//
//   channel  dir  beat carries
//   in_ch    in   data_byte, object_last
//   out_ch   out  kind, char_count, first_char, second_char,
//                 entry_done, is_subtree, object_end, parse_error
//
// one result per input beat, held in the result register and shown in the cycle after its beat is taken
// a new beat is taken every cycle while the result register is empty or being drained
// out_ch stall holds the result and stops input only while the register is full
// rst_n clears the parse state to the header phase and empties the result register

module tree_object_entry_parser #(
    parameter int DIGEST_LEN = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    tope_in_if.sink    in_ch,
    tope_out_if.source out_ch
);

    logic              accept;
    logic              out_valid_reg;
    tope_pkg::result_t res;
    tope_pkg::result_t res_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    tope_parser #(
        .DIGEST_LEN (DIGEST_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .data_byte   (in_ch.data_byte),
        .object_last (in_ch.object_last),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            out_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = res_reg.kind;
    assign out_ch.char_count  = res_reg.char_count;
    assign out_ch.first_char  = res_reg.first_char;
    assign out_ch.second_char = res_reg.second_char;
    assign out_ch.entry_done  = res_reg.entry_done;
    assign out_ch.is_subtree  = res_reg.is_subtree;
    assign out_ch.object_end  = res_reg.object_end;
    assign out_ch.parse_error = res_reg.parse_error;

endmodule

/* hw/rtl/tope_parser.sv */
// tope_parser: parse state registers and the per-byte result logic
// depends on tope_pkg

module tope_parser #(
    parameter int DIGEST_LEN = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             object_last,
    output tope_pkg::result_t res
);

    localparam int CNT_W = $clog2(DIGEST_LEN + 1);

    tope_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] hash_cnt_reg, hash_cnt_next, hash_cnt_inc;
    logic [2:0]       mode_len_reg, mode_len_next;
    logic             mode_match_reg, mode_match_next;

    assign hash_cnt_inc = hash_cnt_reg + {{(CNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        hash_cnt_next   = hash_cnt_reg;
        mode_len_next   = mode_len_reg;
        mode_match_next = mode_match_reg;
        res             = '0;
        res.object_end  = object_last;

        case (phase_reg)
            tope_pkg::PH_HEADER:
            begin
                if (data_byte == tope_pkg::CHAR_NUL)
                begin
                    phase_next      = tope_pkg::PH_MODE;
                    mode_len_next   = 3'd0;
                    mode_match_next = 1'b1;
                    hash_cnt_next   = '0;
                end
            end
            tope_pkg::PH_MODE:
            begin
                if (data_byte == tope_pkg::CHAR_SPACE)
                begin
                    phase_next = tope_pkg::PH_NAME;
                end
                else
                begin
                    res.kind       = tope_pkg::KIND_MODE;
                    res.char_count = 2'd1;
                    res.first_char = data_byte;
                    if (mode_len_reg >= tope_pkg::TREE_MODE_LEN ||
                        data_byte != tope_pkg::tree_mode_char(mode_len_reg))
                    begin
                        mode_match_next = 1'b0;
                    end
                    if (mode_len_reg < tope_pkg::MODE_LEN_MAX)
                    begin
                        mode_len_next = mode_len_reg + 3'd1;
                    end
                end
            end
            tope_pkg::PH_NAME:
            begin
                if (data_byte == tope_pkg::CHAR_NUL)
                begin
                    phase_next    = tope_pkg::PH_HASH;
                    hash_cnt_next = '0;
                end
                else
                begin
                    res.kind       = tope_pkg::KIND_NAME;
                    res.char_count = 2'd1;
                    res.first_char = data_byte;
                end
            end
            tope_pkg::PH_HASH:
            begin
                res.kind        = tope_pkg::KIND_HASH;
                res.char_count  = 2'd2;
                res.first_char  = tope_pkg::hex_char(data_byte[7:4]);
                res.second_char = tope_pkg::hex_char(data_byte[3:0]);
                if (hash_cnt_inc == CNT_W'(DIGEST_LEN))
                begin
                    res.entry_done  = 1'b1;
                    res.is_subtree  = mode_match_reg &&
                                      (mode_len_reg == tope_pkg::TREE_MODE_LEN);
                    phase_next      = tope_pkg::PH_MODE;
                    mode_len_next   = 3'd0;
                    mode_match_next = 1'b1;
                    hash_cnt_next   = '0;
                end
                else
                begin
                    hash_cnt_next = hash_cnt_inc;
                end
            end
            default:
            begin
                phase_next = tope_pkg::PH_HEADER;
            end
        endcase

        // object end: check entry boundary, then back to header
        if (object_last)
        begin
            res.parse_error = !(phase_next == tope_pkg::PH_MODE && mode_len_next == 3'd0);
            phase_next      = tope_pkg::PH_HEADER;
            hash_cnt_next   = '0;
            mode_len_next   = 3'd0;
            mode_match_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tope_pkg::PH_HEADER;
            hash_cnt_reg   <= '0;
            mode_len_reg   <= 3'd0;
            mode_match_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hash_cnt_reg   <= hash_cnt_next;
            mode_len_reg   <= mode_len_next;
            mode_match_reg <= mode_match_next;
        end
    end

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for tree_object_entry_parser, byte stream in, one result per beat
// depends on tope_pkg, tope_in_if, tope_out_if and the parser rtl
// a scoreboard class predicts every result, plain tasks drive well-formed, cut and noise objects

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    DIGEST_LEN   = 32;
    localparam int    RANDOM_BEATS = 1200;
    localparam int    IDLE_LIMIT   = 400;
    localparam string SUBTREE_MODE = "040000";
    localparam string HEX_DIGITS   = "0123456789abcdef";

    typedef logic [7:0] byte_q_t[$];

    class entry_parse_ledger;
        tope_pkg::phase_t  phase;
        logic [5:0]        hash_count;
        logic [2:0]        mode_len;
        logic              mode_ok;
        tope_pkg::result_t awaited[$];
        int                errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = tope_pkg::PH_HEADER;
            hash_count = '0;
            mode_len   = '0;
            mode_ok    = 1'b1;
        endfunction

        function void open_entry();
            clear_state();
            phase = tope_pkg::PH_MODE;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function string show(tope_pkg::result_t r);
            return $sformatf("kind %0d count %0d first %h second %h done %b sub %b end %b err %b",
                             r.kind, r.char_count, r.first_char, r.second_char,
                             r.entry_done, r.is_subtree, r.object_end, r.parse_error);
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            tope_pkg::result_t r;
            r = '0;
            case (phase)
                tope_pkg::PH_HEADER:
                begin
                    if (b == tope_pkg::CHAR_NUL)
                    begin
                        open_entry();
                    end
                end
                tope_pkg::PH_MODE:
                begin
                    if (b == tope_pkg::CHAR_SPACE)
                    begin
                        phase = tope_pkg::PH_NAME;
                    end
                    else
                    begin
                        r.kind       = tope_pkg::KIND_MODE;
                        r.char_count = 2'd1;
                        r.first_char = b;
                        if (mode_len >= tope_pkg::TREE_MODE_LEN || b != SUBTREE_MODE[mode_len])
                        begin
                            mode_ok = 1'b0;
                        end
                        if (mode_len < tope_pkg::MODE_LEN_MAX)
                        begin
                            mode_len = mode_len + 3'd1;
                        end
                    end
                end
                tope_pkg::PH_NAME:
                begin
                    if (b == tope_pkg::CHAR_NUL)
                    begin
                        phase      = tope_pkg::PH_HASH;
                        hash_count = '0;
                    end
                    else
                    begin
                        r.kind       = tope_pkg::KIND_NAME;
                        r.char_count = 2'd1;
                        r.first_char = b;
                    end
                end
                default:
                begin
                    r.kind        = tope_pkg::KIND_HASH;
                    r.char_count  = 2'd2;
                    r.first_char  = HEX_DIGITS[b[7:4]];
                    r.second_char = HEX_DIGITS[b[3:0]];
                    hash_count    = hash_count + 6'd1;
                    if (hash_count >= DIGEST_LEN)
                    begin
                        r.entry_done = 1'b1;
                        r.is_subtree = mode_ok && (mode_len == tope_pkg::TREE_MODE_LEN);
                        open_entry();
                    end
                end
            endcase
            if (last)
            begin
                r.parse_error = !(phase == tope_pkg::PH_MODE && mode_len == 3'd0);
                clear_state();
            end
            r.object_end = last;
            awaited.insert(awaited.size(), r);
        endfunction

        function void check_result(tope_pkg::result_t got);
            tope_pkg::result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected result beat: %s", show(got));
                end
            end
            else
            begin
                want = awaited.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("result mismatch at %0t", $realtime);
                        $display("  expected %s", show(want));
                        $display("  actual   %s", show(got));
                    end
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic calm;
    int   beats_sent;
    int   idle_cycles;

    tope_in_if  in_ch();
    tope_out_if out_ch();

    entry_parse_ledger ledger;

    tree_object_entry_parser #(
        .DIGEST_LEN(DIGEST_LEN)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.object_last <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        ledger.note_byte(b, last);
        beats_sent++;
    endtask

    task automatic send_object(input byte_q_t q);
        calm = ($urandom_range(0, 3) == 0);
        foreach (q[i])
        begin
            send_beat(q[i], i == q.size() - 1);
        end
    endtask

    function automatic byte_q_t make_object();
        byte_q_t    q;
        string      mode_text;
        logic [7:0] c;
        int         n;
        q = {};
        repeat ($urandom_range(0, 6)) q.insert(q.size(), 8'($urandom_range(1, 255)));
        q.insert(q.size(), tope_pkg::CHAR_NUL);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 8))
                0, 1:    mode_text = "040000";
                2:       mode_text = "40000";
                3:       mode_text = "040007";
                4:       mode_text = "0400000";
                5:       mode_text = "100644";
                6:       mode_text = "";
                default: mode_text = "*";
            endcase
            if (mode_text == "*")
            begin
                n = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 6) : $urandom_range(8, 10);
                repeat (n)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == tope_pkg::CHAR_SPACE)
                    begin
                        c = tope_pkg::CHAR_NUL;
                    end
                    q.insert(q.size(), c);
                end
            end
            else
            begin
                foreach (mode_text[i]) q.insert(q.size(), mode_text[i]);
            end
            q.insert(q.size(), tope_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 6)) q.insert(q.size(), 8'($urandom_range(1, 255)));
            q.insert(q.size(), tope_pkg::CHAR_NUL);
            repeat (DIGEST_LEN) q.insert(q.size(), 8'($urandom_range(0, 255)));
        end
        return q;
    endfunction

    initial
    begin
        byte_q_t q;
        int      pick;
        int      cut;
        rst_n             = 1'b0;
        calm              = 1'b0;
        beats_sent        = 0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = 8'h00;
        in_ch.object_last = 1'b0;
        ledger            = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // header only, closed on its nul
        q = {8'h61, 8'h62, tope_pkg::CHAR_NUL};
        send_object(q);
        // ends inside the header
        q = {8'hff};
        send_object(q);
        // nul inside the mode, hash extremes, ends mid-hash
        q = {tope_pkg::CHAR_NUL, 8'h30, tope_pkg::CHAR_NUL, tope_pkg::CHAR_SPACE, 8'h6e,
             tope_pkg::CHAR_NUL, 8'h00, 8'hff};
        send_object(q);
        // empty mode and name
        q = {tope_pkg::CHAR_NUL, tope_pkg::CHAR_SPACE, tope_pkg::CHAR_NUL, 8'h5a};
        send_object(q);
        // ends inside the mode
        q = {tope_pkg::CHAR_NUL, 8'h31};
        send_object(q);
        // ends right after the mode delimiter
        q = {tope_pkg::CHAR_NUL, 8'h30, tope_pkg::CHAR_SPACE};
        send_object(q);

        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                q = make_object();
            end
            else if (pick < 9)
            begin
                q   = make_object();
                cut = (q.size() > 1) ? $urandom_range(1, q.size() - 1) : 1;
                while (q.size() > cut) void'(q.pop_back());
            end
            else
            begin
                q = {};
                repeat ($urandom_range(1, 40))
                begin
                    case ($urandom_range(0, 3))
                        0:       q.insert(q.size(), tope_pkg::CHAR_NUL);
                        1:       q.insert(q.size(), tope_pkg::CHAR_SPACE);
                        default: q.insert(q.size(), 8'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_object(q);
        end
        in_ch.valid <= 1'b0;

        while (ledger.pending() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (ledger.errors == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial
    begin
        tope_pkg::result_t got;
        int                stall;
        out_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_ch.valid);
            got = {out_ch.kind, out_ch.char_count, out_ch.first_char, out_ch.second_char,
                   out_ch.entry_done, out_ch.is_subtree, out_ch.object_end, out_ch.parse_error};
            ledger.check_result(got);
        end
    end

    // no beat on either side for too long means the block has hung
    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding", ledger.pending());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule
